>>> hw/rtl/assert_macros.svh
// Shared assertion macros for the changer checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, reset masks the check
`define CCD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset masks the check
`define CCD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/ccd_pkg.sv
`timescale 1ns / 1ps

package ccd_pkg;

    // Sizing
    localparam int NUM_DENOMS  = 9;
    localparam int COUNT_WIDTH = 16;
    localparam int SLOT_W      = 4;
    localparam int IDX_W       = (NUM_DENOMS > 1) ? $clog2(NUM_DENOMS) : 1;
    localparam int AMT_W       = 16;
    localparam int DENOM_W     = 11;
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = AMT_W + RECIP_W;
    localparam int QV_W        = AMT_W + DENOM_W;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
    localparam logic [AMT_W-1:0]       AMT_MAX   = '1;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Configuration space
    localparam int              PADDR_W         = 3;
    localparam int              PDATA_W         = 32;
    localparam logic            REG_IDX_MAX_PAY = 1'b0;
    localparam logic [AMT_W-1:0] MAX_PAY_RESET  = 16'd2000;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_PAY    = 2'd1,
        REQ_LOAD   = 2'd2
    } t_req;

    typedef enum logic [2:0] {
        STAT_INSERTED    = 3'd0,
        STAT_DISPENSE    = 3'd1,
        STAT_OVER_LIMIT  = 3'd2,
        STAT_UNDERPAID   = 3'd3,
        STAT_CHANGE_DONE = 3'd4,
        STAT_LOADED      = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_EXEC,
        BS_MUL,
        BS_QV,
        BS_FIX,
        BS_DONE
    } t_bstate;

    // Classified command: value is amount due for pay, new stock for load
    typedef struct packed {
        t_req              op;
        logic [SLOT_W-1:0] slot;
        logic              slot_ok;
        logic [AMT_W-1:0]  value;
    } t_cmd;

    typedef struct packed {
        t_status            status;
        logic [SLOT_W-1:0]  out_denom;
        logic [AMT_W-1:0]   piece_count;
        logic [AMT_W-1:0]   amount_cents;
        logic               last;
    } t_result;

    // Face value of each slot in cents
    function automatic logic [DENOM_W-1:0] denom_value(input logic [IDX_W-1:0] idx);
        logic [DENOM_W-1:0] v;
        case (idx)
            IDX_W'(0): v = 11'd1000;
            IDX_W'(1): v = 11'd500;
            IDX_W'(2): v = 11'd100;
            IDX_W'(3): v = 11'd100;
            IDX_W'(4): v = 11'd50;
            IDX_W'(5): v = 11'd25;
            IDX_W'(6): v = 11'd10;
            IDX_W'(7): v = 11'd5;
            IDX_W'(8): v = 11'd1;
            default:   v = '0;
        endcase
        return v;
    endfunction

    // floor(2^RECIP_SHIFT / value), for quotient estimation
    function automatic logic [RECIP_W-1:0] denom_recip(input logic [IDX_W-1:0] idx);
        logic [RECIP_W-1:0] r;
        case (idx)
            IDX_W'(0): r = 25'd16777;
            IDX_W'(1): r = 25'd33554;
            IDX_W'(2): r = 25'd167772;
            IDX_W'(3): r = 25'd167772;
            IDX_W'(4): r = 25'd335544;
            IDX_W'(5): r = 25'd671088;
            IDX_W'(6): r = 25'd1677721;
            IDX_W'(7): r = 25'd3355443;
            IDX_W'(8): r = 25'd16777216;
            default:   r = '0;
        endcase
        return r;
    endfunction

endpackage

>>> hw/rtl/coin_change_dispenser.sv
`timescale 1ns / 1ps
// Coin changer over nine fixed denomination slots, amounts in cents.
// Input channel (i_valid / o_stall): insert a piece, load a slot's stock, or pay.
// Output channel (o_valid / i_stall): one result transfer for insert and load,
// for pay either a reject, or dispense lines followed by a change-done item.
// o_last marks the final result of each request; unknown requests give none.
// An insert or load result passes the input register, the command queue and the
// sequencer's command register on its way to the result register. A pay request
// walks the nine slots, each by reciprocal multiply, quotient times value, then
// correction and stock check. The sequencer takes no new request until it is idle.
// A 4-entry command queue sits between the input register and the sequencer,
// so requests keep being taken while a pay is in progress.
// When the receiver stalls, the result register holds and the sequencer waits
// at its next result; the queue fills and then o_stall rises.
// Reset (synchronous, active low) clears stock, received total and all queues,
// and sets the limit register max_payment_cents (byte address 0) to 2000.

module coin_change_dispenser (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [1:0]                  i_req_type,
    input  logic [ccd_pkg::SLOT_W-1:0]  i_denom_index,
    input  logic [ccd_pkg::AMT_W-1:0]   i_amount_due,
    input  logic [ccd_pkg::AMT_W-1:0]   i_load_count,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [2:0]                  o_status,
    output logic [ccd_pkg::SLOT_W-1:0]  o_out_denom,
    output logic [ccd_pkg::AMT_W-1:0]   o_piece_count,
    output logic [ccd_pkg::AMT_W-1:0]   o_amount_cents,
    output logic                        o_last,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ccd_pkg::PADDR_W-1:0] paddr,
    input  logic [ccd_pkg::PDATA_W-1:0] pwdata,
    output logic [ccd_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);

    logic [ccd_pkg::AMT_W-1:0] r_max_pay;
    logic                      reg_hit;
    logic                      q_push, q_full, q_pop, q_empty;
    ccd_pkg::t_cmd             push_cmd, head_cmd;
    ccd_pkg::t_result          res;

    // Configuration port
    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == ccd_pkg::REG_IDX_MAX_PAY);
    assign prdata  = reg_hit ? ccd_pkg::PDATA_W'(r_max_pay) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_pay <= ccd_pkg::MAX_PAY_RESET;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            r_max_pay <= pwdata[ccd_pkg::AMT_W-1:0];
        end
    end

    ccd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_req_type    (i_req_type),
        .i_denom_index (i_denom_index),
        .i_amount_due  (i_amount_due),
        .i_load_count  (i_load_count),
        .o_push        (q_push),
        .o_cmd         (push_cmd),
        .i_full        (q_full)
    );

    ccd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_cmd   (head_cmd)
    );

    ccd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_empty   (q_empty),
        .i_cmd     (head_cmd),
        .o_pop     (q_pop),
        .i_max_pay (r_max_pay),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_res     (res)
    );

    // Result fields
    assign o_status       = res.status;
    assign o_out_denom    = res.out_denom;
    assign o_piece_count  = res.piece_count;
    assign o_amount_cents = res.amount_cents;
    assign o_last         = res.last;

endmodule

>>> hw/rtl/ccd_front.sv
`timescale 1ns / 1ps

module ccd_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [1:0]                 i_req_type,
    input  logic [ccd_pkg::SLOT_W-1:0] i_denom_index,
    input  logic [ccd_pkg::AMT_W-1:0]  i_amount_due,
    input  logic [ccd_pkg::AMT_W-1:0]  i_load_count,
    output logic                       o_push,
    output ccd_pkg::t_cmd              o_cmd,
    input  logic                       i_full
);

    logic          r_valid, n_valid;
    ccd_pkg::t_cmd r_cmd, n_cmd;
    logic          accept;
    logic          known;

    // Input register, held while the queue is full
    assign o_stall = r_valid && i_full;
    assign accept  = i_valid && !o_stall;
    assign o_push  = r_valid && !i_full;
    assign o_cmd   = r_cmd;

    // Classify: unknown requests are taken and dropped
    always_comb begin
        known = (i_req_type == ccd_pkg::REQ_INSERT) || (i_req_type == ccd_pkg::REQ_PAY)
             || (i_req_type == ccd_pkg::REQ_LOAD);
        n_cmd         = r_cmd;
        n_cmd.op      = ccd_pkg::t_req'(i_req_type);
        n_cmd.slot    = i_denom_index;
        n_cmd.slot_ok = int'(i_denom_index) < ccd_pkg::NUM_DENOMS;
        n_cmd.value   = (i_req_type == ccd_pkg::REQ_PAY) ? i_amount_due : i_load_count;
        if (accept) begin
            n_valid = known;
        end else if (o_push) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

>>> hw/rtl/ccd_queue.sv
`timescale 1ns / 1ps

module ccd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ccd_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output ccd_pkg::t_cmd o_cmd
);

    ccd_pkg::t_cmd                r_mem [ccd_pkg::QUEUE_DEPTH];
    logic [ccd_pkg::QPTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [ccd_pkg::QPTR_W:0]     r_count;
    logic                         do_push, do_pop;

    assign o_full  = (r_count == (ccd_pkg::QPTR_W+1)'(ccd_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

>>> hw/rtl/ccd_back.sv
`timescale 1ns / 1ps

module ccd_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_empty,
    input  ccd_pkg::t_cmd             i_cmd,
    output logic                      o_pop,
    input  logic [ccd_pkg::AMT_W-1:0] i_max_pay,
    output logic                      o_valid,
    input  logic                      i_stall,
    output ccd_pkg::t_result          o_res
);

    localparam int CW = ccd_pkg::COUNT_WIDTH;
    localparam int AW = ccd_pkg::AMT_W;
    localparam int XW = (CW > AW) ? CW : AW;

    ccd_pkg::t_bstate             r_state, n_state;
    ccd_pkg::t_cmd                r_cmd, n_cmd;
    logic [ccd_pkg::IDX_W-1:0]    r_slot, n_slot;
    logic [AW-1:0]                r_total, n_total;
    logic [AW-1:0]                r_change, n_change;
    logic [ccd_pkg::PROD_W-1:0]   r_prod, n_prod;
    logic [AW-1:0]                r_q, n_q;
    logic [AW-1:0]                r_qv, n_qv;
    logic [CW-1:0]                r_stock [ccd_pkg::NUM_DENOMS];
    logic                         r_out_valid;
    ccd_pkg::t_result             r_res;

    logic                         out_free;
    logic                         emit;
    ccd_pkg::t_result             res;
    logic                         stock_we;
    logic [CW-1:0]                stock_wdata;
    logic [CW-1:0]                stock_rd;
    logic [ccd_pkg::DENOM_W-1:0]  denom;
    logic [AW:0]                  sum;
    logic [AW-1:0]                q_est;
    logic [ccd_pkg::QV_W-1:0]     qv_full;
    logic [AW-1:0]                rem;
    logic [AW-1:0]                q_fix;
    logic                         take;

    assign out_free = !r_out_valid || !i_stall;
    assign stock_rd = r_stock[r_slot];
    assign denom    = ccd_pkg::denom_value(r_slot);
    assign o_valid  = r_out_valid;
    assign o_res    = r_res;

    // Sequencer: simple requests in one step, pay walks the slots
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_slot      = r_slot;
        n_total     = r_total;
        n_change    = r_change;
        n_prod      = r_prod;
        n_q         = r_q;
        n_qv        = r_qv;
        o_pop       = 1'b0;
        emit        = 1'b0;
        res         = '0;
        stock_we    = 1'b0;
        stock_wdata = stock_rd;
        sum         = {1'b0, r_total} + (AW+1)'(denom);
        q_est       = AW'(r_prod >> ccd_pkg::RECIP_SHIFT);
        qv_full     = ccd_pkg::QV_W'(q_est) * ccd_pkg::QV_W'(denom);
        rem         = r_change - r_qv;
        q_fix       = r_q;
        if ((denom != '0) && (rem >= AW'(denom))) begin
            q_fix = r_q + 1'b1;
            rem   = rem - AW'(denom);
        end
        take = (q_fix != '0) && (XW'(q_fix) <= XW'(stock_rd));

        case (r_state)
            ccd_pkg::BS_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_cmd   = i_cmd;
                    n_slot  = i_cmd.slot_ok ? ccd_pkg::IDX_W'(i_cmd.slot) : '0;
                    n_state = ccd_pkg::BS_EXEC;
                end
            end
            ccd_pkg::BS_EXEC: begin
                if (out_free) begin
                    n_state          = ccd_pkg::BS_IDLE;
                    res.out_denom    = r_cmd.slot;
                    res.amount_cents = r_total;
                    res.last         = 1'b1;
                    case (r_cmd.op)
                        ccd_pkg::REQ_INSERT: begin
                            emit       = 1'b1;
                            res.status = ccd_pkg::STAT_INSERTED;
                            if (r_cmd.slot_ok) begin
                                // saturating total, saturating stock
                                n_total          = sum[AW] ? ccd_pkg::AMT_MAX : sum[AW-1:0];
                                stock_we         = 1'b1;
                                stock_wdata      = (stock_rd == ccd_pkg::COUNT_MAX) ?
                                                   stock_rd : stock_rd + 1'b1;
                                res.piece_count  = AW'(stock_wdata);
                                res.amount_cents = n_total;
                            end
                        end
                        ccd_pkg::REQ_LOAD: begin
                            emit       = 1'b1;
                            res.status = ccd_pkg::STAT_LOADED;
                            if (r_cmd.slot_ok) begin
                                stock_we        = 1'b1;
                                stock_wdata     = CW'(r_cmd.value);
                                res.piece_count = AW'(stock_wdata);
                            end
                        end
                        ccd_pkg::REQ_PAY: begin
                            n_total       = '0;
                            res.out_denom = '0;
                            if (r_total > i_max_pay) begin
                                emit       = 1'b1;
                                res.status = ccd_pkg::STAT_OVER_LIMIT;
                            end else if (r_total < r_cmd.value) begin
                                emit       = 1'b1;
                                res.status = ccd_pkg::STAT_UNDERPAID;
                            end else begin
                                n_change = r_total - r_cmd.value;
                                n_slot   = '0;
                                n_state  = ccd_pkg::BS_MUL;
                            end
                        end
                        default: begin
                            n_state = ccd_pkg::BS_IDLE;
                        end
                    endcase
                end
            end
            // quotient estimate by reciprocal
            ccd_pkg::BS_MUL: begin
                n_prod  = ccd_pkg::PROD_W'(r_change) * ccd_pkg::PROD_W'(
                          ccd_pkg::denom_recip(r_slot));
                n_state = ccd_pkg::BS_QV;
            end
            ccd_pkg::BS_QV: begin
                n_q     = q_est;
                n_qv    = qv_full[AW-1:0];
                n_state = ccd_pkg::BS_FIX;
            end
            // correct by one, check stock, hand out the line
            ccd_pkg::BS_FIX: begin
                if (!take || out_free) begin
                    if (take) begin
                        stock_we         = 1'b1;
                        stock_wdata      = stock_rd - CW'(q_fix);
                        n_change         = rem;
                        emit             = 1'b1;
                        res.status       = ccd_pkg::STAT_DISPENSE;
                        res.out_denom    = ccd_pkg::SLOT_W'(r_slot);
                        res.piece_count  = q_fix;
                        res.amount_cents = rem;
                        res.last         = 1'b0;
                    end
                    if (r_slot == ccd_pkg::IDX_W'(ccd_pkg::NUM_DENOMS - 1)) begin
                        n_state = ccd_pkg::BS_DONE;
                    end else begin
                        n_slot  = r_slot + 1'b1;
                        n_state = ccd_pkg::BS_MUL;
                    end
                end
            end
            ccd_pkg::BS_DONE: begin
                if (out_free) begin
                    emit             = 1'b1;
                    res.status       = ccd_pkg::STAT_CHANGE_DONE;
                    res.amount_cents = r_change;
                    res.last         = 1'b1;
                    n_state          = ccd_pkg::BS_IDLE;
                end
            end
            default: begin
                n_state = ccd_pkg::BS_IDLE;
            end
        endcase
    end

    // Control state, totals and stock
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ccd_pkg::BS_IDLE;
            r_total     <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < ccd_pkg::NUM_DENOMS; i++) begin
                r_stock[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_total <= n_total;
            if (stock_we) begin
                r_stock[r_slot] <= stock_wdata;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_slot   <= n_slot;
        r_change <= n_change;
        r_prod   <= n_prod;
        r_q      <= n_q;
        r_qv     <= n_qv;
        if (emit) begin
            r_res <= res;
        end
    end

endmodule

>>> hw/rtl/ccd_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ccd_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_valid,
    input logic                       i_stall,
    input logic [2:0]                 o_status,
    input logic [ccd_pkg::SLOT_W-1:0] o_out_denom,
    input logic [ccd_pkg::AMT_W-1:0]  o_piece_count,
    input logic [ccd_pkg::AMT_W-1:0]  o_amount_cents,
    input logic                       o_last
);

    // A stalled result transfer holds
    `CCD_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_status) && $stable(o_piece_count) && $stable(o_amount_cents) && $stable(o_last) && $stable(o_out_denom), "result changed under stall")

    // Dispense lines are never final and always hand out something
    `CCD_ASSERT_NOW(a_disp_line, i_clk, i_rst_n, o_valid && (o_status == ccd_pkg::STAT_DISPENSE), !o_last && (o_piece_count != '0), "bad dispense line")

    // Every other result closes its request
    `CCD_ASSERT_NOW(a_close, i_clk, i_rst_n, o_valid && (o_status != ccd_pkg::STAT_DISPENSE), o_last, "non-dispense result not last")

    // Pay outcomes carry no slot and no pieces
    `CCD_ASSERT_NOW(a_pay_end, i_clk, i_rst_n, o_valid && ((o_status == ccd_pkg::STAT_OVER_LIMIT) || (o_status == ccd_pkg::STAT_UNDERPAID) || (o_status == ccd_pkg::STAT_CHANGE_DONE)), (o_out_denom == '0) && (o_piece_count == '0), "pay outcome carries pieces")

endmodule

bind coin_change_dispenser ccd_checker u_ccd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_status       (o_status),
    .o_out_denom    (o_out_denom),
    .o_piece_count  (o_piece_count),
    .o_amount_cents (o_amount_cents),
    .o_last         (o_last)
);

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    // Request code with no meaning to the changer; it must be dropped silently
    localparam logic [1:0]                  REQ_UNKNOWN   = 2'd3;
    localparam logic [ccd_pkg::PADDR_W-1:0] MAX_PAY_ADDR  =
        ccd_pkg::PADDR_W'(4 * ccd_pkg::REG_IDX_MAX_PAY);
    localparam int                          SETTLE_CYCLES = 64;
    localparam int                          RUN_LIMIT     = 500000;

    typedef struct packed {
        logic [1:0]                 kind;
        logic [ccd_pkg::SLOT_W-1:0] slot;
        logic [ccd_pkg::AMT_W-1:0]  due;
        logic [ccd_pkg::AMT_W-1:0]  count;
        logic [3:0]                 gap;
    } t_coin_req;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_valid = 1'b0;
    logic                          o_stall;
    logic [1:0]                    i_req_type = ccd_pkg::REQ_INSERT;
    logic [ccd_pkg::SLOT_W-1:0]    i_denom_index = '0;
    logic [ccd_pkg::AMT_W-1:0]     i_amount_due = '0;
    logic [ccd_pkg::AMT_W-1:0]     i_load_count = '0;
    logic                          o_valid;
    logic                          i_stall = 1'b0;
    logic [2:0]                    o_status;
    logic [ccd_pkg::SLOT_W-1:0]    o_out_denom;
    logic [ccd_pkg::AMT_W-1:0]     o_piece_count;
    logic [ccd_pkg::AMT_W-1:0]     o_amount_cents;
    logic                          o_last;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [ccd_pkg::PADDR_W-1:0]   paddr;
    logic [ccd_pkg::PDATA_W-1:0]   pwdata;
    logic [ccd_pkg::PDATA_W-1:0]   prdata;
    logic                          pready;

    // Changer state as the block should hold it
    logic [ccd_pkg::COUNT_WIDTH-1:0] stock_model [0:ccd_pkg::NUM_DENOMS-1] = '{default: '0};
    logic [ccd_pkg::AMT_W-1:0]       paid_in = '0;
    logic [ccd_pkg::AMT_W-1:0]       pay_limit;

    t_coin_req        queued_requests [$];
    ccd_pkg::t_result predicted_replies [$];
    t_coin_req        on_wire;
    int               hold_cycles;
    int               stall_left;
    int               error_count = 0;
    int               cycle_count = 0;
    int               queued_items;
    int               planned_total;
    bit               tx_calm;

    coin_change_dispenser dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_req_type     (i_req_type),
        .i_denom_index  (i_denom_index),
        .i_amount_due   (i_amount_due),
        .i_load_count   (i_load_count),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_out_denom    (o_out_denom),
        .o_piece_count  (o_piece_count),
        .o_amount_cents (o_amount_cents),
        .o_last         (o_last),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Face value of a slot in cents; empty slots are worth nothing
    function automatic int unsigned face_cents(input logic [ccd_pkg::SLOT_W-1:0] slot);
        case (slot)
            4'd0:    return 1000;
            4'd1:    return 500;
            4'd2:    return 100;
            4'd3:    return 100;
            4'd4:    return 50;
            4'd5:    return 25;
            4'd6:    return 10;
            4'd7:    return 5;
            4'd8:    return 1;
            default: return 0;
        endcase
    endfunction

    function automatic void push_reply(input ccd_pkg::t_status st,
                                       input logic [ccd_pkg::SLOT_W-1:0] den,
                                       input logic [ccd_pkg::AMT_W-1:0] pcs,
                                       input logic [ccd_pkg::AMT_W-1:0] amt,
                                       input logic lst);
        ccd_pkg::t_result r;
        r.status       = st;
        r.out_denom    = den;
        r.piece_count  = pcs;
        r.amount_cents = amt;
        r.last         = lst;
        predicted_replies.push_back(r);
    endfunction

    // Works out the replies to one accepted request and updates the changer state
    function automatic void predict_replies(input t_coin_req rq);
        int unsigned               got;
        int unsigned               change;
        int unsigned               face;
        int unsigned               q;
        logic [ccd_pkg::AMT_W-1:0] pcs;
        pcs = '0;
        case (rq.kind)
            ccd_pkg::REQ_INSERT: begin
                if (rq.slot < ccd_pkg::NUM_DENOMS) begin
                    got = paid_in + face_cents(rq.slot);
                    paid_in = (got > ccd_pkg::AMT_MAX) ? ccd_pkg::AMT_MAX :
                              ccd_pkg::AMT_W'(got);
                    if (stock_model[rq.slot] != ccd_pkg::COUNT_MAX)
                        stock_model[rq.slot] = stock_model[rq.slot] + 1'b1;
                    pcs = stock_model[rq.slot];
                end
                push_reply(ccd_pkg::STAT_INSERTED, rq.slot, pcs, paid_in, 1'b1);
            end
            ccd_pkg::REQ_LOAD: begin
                if (rq.slot < ccd_pkg::NUM_DENOMS) begin
                    stock_model[rq.slot] = ccd_pkg::COUNT_WIDTH'(rq.count);
                    pcs = stock_model[rq.slot];
                end
                push_reply(ccd_pkg::STAT_LOADED, rq.slot, pcs, paid_in, 1'b1);
            end
            ccd_pkg::REQ_PAY: begin
                got = paid_in;
                paid_in = '0;
                if (got > pay_limit) begin
                    push_reply(ccd_pkg::STAT_OVER_LIMIT, '0, '0, ccd_pkg::AMT_W'(got), 1'b1);
                end else if (got < rq.due) begin
                    push_reply(ccd_pkg::STAT_UNDERPAID, '0, '0, ccd_pkg::AMT_W'(got), 1'b1);
                end else begin
                    // greedy walk, a slot only pays when it covers the whole quotient
                    change = got - rq.due;
                    for (int s = 0; s < ccd_pkg::NUM_DENOMS; s++) begin
                        face = face_cents(ccd_pkg::SLOT_W'(s));
                        if (face != 0 && face <= change) begin
                            q = change / face;
                            if (q <= stock_model[s]) begin
                                stock_model[s] = stock_model[s] - ccd_pkg::COUNT_WIDTH'(q);
                                change = change - q * face;
                                push_reply(ccd_pkg::STAT_DISPENSE, ccd_pkg::SLOT_W'(s),
                                           ccd_pkg::AMT_W'(q), ccd_pkg::AMT_W'(change),
                                           1'b0);
                            end
                        end
                    end
                    push_reply(ccd_pkg::STAT_CHANGE_DONE, '0, '0, ccd_pkg::AMT_W'(change),
                               1'b1);
                end
            end
            default: ;  // unknown request: no reply
        endcase
    endfunction

    // Request driver: honours each request's idle gap, predicts on every transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            hold_cycles = 0;
        end else begin
            if (i_valid && !o_stall)
                predict_replies(on_wire);
            if (!i_valid || !o_stall) begin
                if (queued_requests.size() != 0 &&
                    hold_cycles >= queued_requests[0].gap) begin
                    on_wire = queued_requests.pop_front();
                    i_valid       <= 1'b1;
                    i_req_type    <= on_wire.kind;
                    i_denom_index <= on_wire.slot;
                    i_amount_due  <= on_wire.due;
                    i_load_count  <= on_wire.count;
                    hold_cycles = 0;
                end else begin
                    i_valid <= 1'b0;
                    if (queued_requests.size() != 0)
                        hold_cycles++;
                end
            end
        end
    end

    task automatic flag_error(input string what);
        if (error_count < 10)
            $display("%s", what);
        error_count++;
    endtask

    // Reply monitor: random back-pressure, calm for a quarter of the run
    always @(posedge i_clk) begin : reply_check
        ccd_pkg::t_result want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (predicted_replies.size() == 0) begin
                    flag_error($sformatf({"tb_top: unexpected reply st %0d den %0d ",
                                          "pcs %0d amt %0d last %0d"},
                                         o_status, o_out_denom, o_piece_count,
                                         o_amount_cents, o_last));
                end else begin
                    want = predicted_replies.pop_front();
                    if (o_status !== want.status || o_out_denom !== want.out_denom ||
                        o_piece_count !== want.piece_count ||
                        o_amount_cents !== want.amount_cents || o_last !== want.last)
                        flag_error($sformatf({"tb_top: reply mismatch, expected st %0d den %0d ",
                                              "pcs %0d amt %0d last %0d, got %0d %0d %0d %0d %0d"},
                                             want.status, want.out_denom, want.piece_count,
                                             want.amount_cents, want.last, o_status, o_out_denom,
                                             o_piece_count, o_amount_cents, o_last));
                end
                stall_left = ((cycle_count % 1024) < 256) ? 0 : $urandom_range(0, 11);
            end else if (stall_left > 0) begin
                stall_left--;
            end
            i_stall <= (stall_left > 0);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    task automatic queue_req(input logic [1:0] kind, input int slot, input int due,
                             input int count);
        t_coin_req rq;
        rq.kind  = kind;
        rq.slot  = ccd_pkg::SLOT_W'(slot);
        rq.due   = ccd_pkg::AMT_W'(due);
        rq.count = ccd_pkg::AMT_W'(count);
        rq.gap   = tx_calm ? 4'd0 : 4'($urandom_range(0, 11));
        queued_requests.push_back(rq);
        queued_items++;
        // rough tally of the money in, used only to shape the stimulus
        if (kind == ccd_pkg::REQ_INSERT && slot < ccd_pkg::NUM_DENOMS)
            planned_total = (planned_total + face_cents(rq.slot) > 65535) ? 65535 :
                            planned_total + face_cents(rq.slot);
        else if (kind == ccd_pkg::REQ_PAY)
            planned_total = 0;
    endtask

    // Well-formed purchase: maybe restock, insert money within the limit, pay
    task automatic queue_purchase();
        int slot;
        int due;
        repeat ($urandom_range(0, 2))
            queue_req(ccd_pkg::REQ_LOAD, $urandom_range(0, 8), $urandom_range(0, 65535),
                      ($urandom_range(0, 7) == 0) ? $urandom_range(0, 300) :
                                                    $urandom_range(0, 5));
        repeat ($urandom_range(1, 5)) begin
            slot = $urandom_range(0, 8);
            while (slot < 8 &&
                   planned_total + face_cents(ccd_pkg::SLOT_W'(slot)) > pay_limit)
                slot++;
            if (planned_total + face_cents(ccd_pkg::SLOT_W'(slot)) <= pay_limit)
                queue_req(ccd_pkg::REQ_INSERT, slot, $urandom_range(0, 65535),
                          $urandom_range(0, 65535));
        end
        due = ($urandom_range(0, 3) == 0) ? planned_total : $urandom_range(0, planned_total);
        queue_req(ccd_pkg::REQ_PAY, $urandom_range(0, 15), due, $urandom_range(0, 65535));
    endtask

    // Junk and broken sequences
    task automatic queue_noise();
        int due;
        case ($urandom_range(0, 4))
            0: queue_req(REQ_UNKNOWN, $urandom_range(0, 15), $urandom_range(0, 65535),
                         $urandom_range(0, 65535));
            1: queue_req($urandom_range(0, 1) ? ccd_pkg::REQ_INSERT : ccd_pkg::REQ_LOAD,
                         $urandom_range(9, 15), $urandom_range(0, 65535),
                         $urandom_range(0, 65535));
            2: queue_req(ccd_pkg::REQ_LOAD, $urandom_range(0, 8), $urandom_range(0, 65535),
                         $urandom_range(0, 65535));
            3: begin
                // underpaid
                queue_req(ccd_pkg::REQ_INSERT, $urandom_range(0, 8), $urandom_range(0, 65535),
                          $urandom_range(0, 65535));
                due = (planned_total < 65535) ? $urandom_range(planned_total + 1, 65535) : 65535;
                queue_req(ccd_pkg::REQ_PAY, $urandom_range(0, 15), due,
                          $urandom_range(0, 65535));
            end
            default: begin
                // large notes, usually over the limit
                repeat ($urandom_range(1, 4))
                    queue_req(ccd_pkg::REQ_INSERT, $urandom_range(0, 1),
                              $urandom_range(0, 65535), $urandom_range(0, 65535));
                queue_req(ccd_pkg::REQ_PAY, $urandom_range(0, 15),
                          $urandom_range(0, planned_total), $urandom_range(0, 65535));
            end
        endcase
    endtask

    task automatic queue_random(input int n_items);
        int target;
        target = queued_items + n_items;
        while (queued_items < target) begin
            tx_calm = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 3) == 0)
                queue_noise();
            else
                queue_purchase();
        end
        tx_calm = 1'b0;
    endtask

    task automatic queue_directed();
        queue_req(ccd_pkg::REQ_PAY, 0, 0, 0);                // nothing paid in, nothing owed
        queue_req(ccd_pkg::REQ_LOAD, 0, 0, 16'hFFFF);
        queue_req(ccd_pkg::REQ_INSERT, 0, 0, 0);             // stock stays at its maximum
        queue_req(ccd_pkg::REQ_LOAD, 15, 16'hFFFF, 16'hA5A5); // empty slot
        queue_req(ccd_pkg::REQ_INSERT, 9, 0, 0);
        queue_req(REQ_UNKNOWN, 5, 16'hFFFF, 16'hFFFF);
        queue_req(ccd_pkg::REQ_INSERT, 1, 0, 0);
        queue_req(ccd_pkg::REQ_INSERT, 4, 0, 0);
        queue_req(ccd_pkg::REQ_INSERT, 0, 0, 0);
        queue_req(ccd_pkg::REQ_PAY, 0, 0, 0);                // over the limit
        queue_req(ccd_pkg::REQ_PAY, 0, 16'hFFFF, 0);         // underpaid with nothing in
        queue_req(ccd_pkg::REQ_LOAD, 1, 0, 1);
        queue_req(ccd_pkg::REQ_LOAD, 2, 0, 0);
        queue_req(ccd_pkg::REQ_LOAD, 3, 0, 3);
        queue_req(ccd_pkg::REQ_LOAD, 4, 0, 1);
        queue_req(ccd_pkg::REQ_LOAD, 5, 0, 1);
        queue_req(ccd_pkg::REQ_LOAD, 6, 0, 2);
        queue_req(ccd_pkg::REQ_LOAD, 7, 0, 1);
        queue_req(ccd_pkg::REQ_LOAD, 8, 0, 3);
        queue_req(ccd_pkg::REQ_INSERT, 0, 0, 0);
        queue_req(ccd_pkg::REQ_INSERT, 0, 0, 0);             // exactly at the limit
        queue_req(ccd_pkg::REQ_PAY, 15, 13, 16'hFFFF);       // change runs short
        queue_req(ccd_pkg::REQ_INSERT, 8, 0, 0);
        queue_req(ccd_pkg::REQ_PAY, 0, 1, 0);                // exact payment
    endtask

    // Saturate the received total (66 ten-dollar notes overflow it), then pay with nothing owed
    task automatic queue_saturation();
        queue_req(ccd_pkg::REQ_LOAD, 0, 0, 0);
        repeat (66)
            queue_req(ccd_pkg::REQ_INSERT, 0, $urandom_range(0, 65535),
                      $urandom_range(0, 65535));
        queue_req(ccd_pkg::REQ_PAY, 0, 0, 0);
    endtask

    task automatic write_max_payment(input logic [ccd_pkg::AMT_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MAX_PAY_ADDR;
        pwdata  <= ccd_pkg::PDATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        pay_limit = value;
        @(negedge i_clk);
    endtask

    // Wait for every reply, then let any dropped request drain
    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (queued_requests.size() != 0 || i_valid || predicted_replies.size() != 0);
        repeat (SETTLE_CYCLES)
            @(posedge i_clk);
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        queued_items  = 0;
        planned_total = 0;
        tx_calm       = 1'b0;
        pay_limit     = ccd_pkg::MAX_PAY_RESET;

        repeat (2)
            @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset limit
        queue_directed();
        wait_idle();

        // widest limit
        write_max_payment(16'hFFFF);
        queue_saturation();
        queue_random(18);
        wait_idle();

        // zero limit: only empty payments pass
        write_max_payment(16'h0000);
        queue_random(12);
        wait_idle();

        write_max_payment(ccd_pkg::AMT_W'($urandom_range(100, 5000)));
        queue_random(18);
        wait_idle();

        write_max_payment(16'd2000);
        queue_random(12);
        wait_idle();

        if (error_count == 0 && predicted_replies.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
